@@ design/fcta_pkg.sv @@
// ----------------------------------------------------------------------------
// fcta_pkg
// Types, operation codes and constants shared by the cluster table allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcta_pkg;

    localparam int VAL_W = 28;
    localparam int CFG_W = 17;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CFG_W-1:0] cfg_t;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam val_t EOC_THRESHOLD = 28'hFFF_FFF8;
    localparam val_t EOC_MARK      = 28'hFFF_FFFF;

    localparam cfg_t ENTRIES_RESET = 17'h1_0000;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic do_load;
        logic set_invalid;
        logic set_empty;
        logic rd_issue;
        logic rd_finish;
        logic alloc_start;
        logic scan_step;
        logic out_load;
    } fcta_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] op;
        logic       idx_bad;
        logic       ptr_zero;
        logic       ptr_bad;
        logic       scan_done;
    } fcta_sts_t;

endpackage

`default_nettype wire

@@ design/fcta_if.sv @@
// ----------------------------------------------------------------------------
// fcta_if
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcta_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    fcta_pkg::val_t       cluster_index;
    fcta_pkg::val_t       new_value;

    modport source (output valid, output operation, output cluster_index,
                    output new_value, input ready);
    modport sink   (input valid, input operation, input cluster_index,
                    input new_value, output ready);
endinterface

interface fcta_out_if;
    logic                 valid;
    logic                 ready;
    logic                 status;
    fcta_pkg::val_t       entry_value;
    logic                 end_of_chain;
    fcta_pkg::val_t       free_count;

    modport source (output valid, output status, output entry_value,
                    output end_of_chain, output free_count, input ready);
    modport sink   (input valid, input status, input entry_value,
                    input end_of_chain, input free_count, output ready);
endinterface

`default_nettype wire

@@ design/fcta_datapath.sv @@
// ----------------------------------------------------------------------------
// fcta_datapath
// Cluster table memory, pointer and free count, scan engine, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fcta_datapath #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fcta_pkg::fcta_cmd_t cmd,
    output fcta_pkg::fcta_sts_t      sts,
    input  wire fcta_pkg::cfg_t      entries_in_use,
    input  wire logic [1:0]          operation,
    input  wire fcta_pkg::val_t      cluster_index,
    input  wire fcta_pkg::val_t      new_value,
    output logic                     status,
    output fcta_pkg::val_t           entry_value,
    output logic                     end_of_chain,
    output fcta_pkg::val_t           free_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam fcta_pkg::val_t TABLE_LIM = fcta_pkg::val_t'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    fcta_pkg::val_t mem [TABLE_ENTRIES];

    logic [1:0]     op_reg;
    fcta_pkg::val_t idx_reg;
    fcta_pkg::val_t val_reg;
    fcta_pkg::val_t ptr_reg;
    fcta_pkg::val_t free_reg;
    logic           res_status_reg;
    fcta_pkg::val_t res_entry_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] scan_addr_reg;
    logic             scan_issued_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    fcta_pkg::val_t   rdata_reg;

    fcta_pkg::val_t   lim;
    logic [IDX_W-1:0] ptr_idx;
    logic [IDX_W-1:0] idx_idx;
    logic             scan_hit;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    fcta_pkg::val_t   wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a,
                                                  input fcta_pkg::val_t l);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {{IDX_W{1'b0}}, 1'b1};
        return (fcta_pkg::val_t'(s) == l) ? '0 : s[IDX_W-1:0];
    endfunction

    assign lim = (fcta_pkg::val_t'(entries_in_use) > TABLE_LIM) ?
                 TABLE_LIM : fcta_pkg::val_t'(entries_in_use);
    assign ptr_idx  = ptr_reg[IDX_W-1:0];
    assign idx_idx  = idx_reg[IDX_W-1:0];
    assign scan_hit = rd_valid_reg && ((rdata_reg == '0) || (rd_addr_reg == ptr_idx));

    always_comb
    begin
        sts.clr_last  = (clr_cnt_reg == LAST_IDX);
        sts.op        = op_reg;
        sts.idx_bad   = (idx_reg >= lim);
        sts.ptr_zero  = (ptr_reg == '0);
        sts.ptr_bad   = (ptr_reg >= lim);
        sts.scan_done = scan_hit;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        priority if (cmd.clr_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.alloc_start)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_idx;
            wr_data = fcta_pkg::EOC_MARK;
        end
        else if (cmd.rd_finish && (op_reg == fcta_pkg::OP_WRITE))
        begin
            wr_en   = 1'b1;
            wr_addr = idx_idx;
            wr_data = val_reg;
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_addr_reg;
        priority if (cmd.rd_issue)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_idx;
        end
        else if (cmd.scan_step && !scan_issued_reg)
        begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            idx_reg <= cluster_index;
            val_reg <= new_value;
        end
        priority if (cmd.set_invalid)
        begin
            res_status_reg <= fcta_pkg::STATUS_INVALID;
            res_entry_reg  <= '0;
        end
        else if (cmd.set_empty || cmd.do_load)
        begin
            res_status_reg <= fcta_pkg::STATUS_OK;
            res_entry_reg  <= '0;
        end
        else if (cmd.alloc_start)
        begin
            res_status_reg <= fcta_pkg::STATUS_OK;
            res_entry_reg  <= ptr_reg;
        end
        else if (cmd.rd_finish)
        begin
            res_status_reg <= fcta_pkg::STATUS_OK;
            res_entry_reg  <= rdata_reg;
        end
        if (cmd.out_load)
        begin
            status       <= res_status_reg;
            entry_value  <= res_entry_reg;
            end_of_chain <= (res_entry_reg >= fcta_pkg::EOC_THRESHOLD);
            free_count   <= free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            free_reg        <= '0;
            clr_cnt_reg     <= '0;
            scan_addr_reg   <= '0;
            scan_issued_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
            rd_addr_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.do_load)
            begin
                ptr_reg  <= idx_reg;
                free_reg <= val_reg;
            end
            if (cmd.alloc_start)
            begin
                if (free_reg != '0)
                begin
                    free_reg <= free_reg - 1'b1;
                end
                scan_addr_reg   <= wrap_inc(ptr_idx, lim);
                scan_issued_reg <= 1'b0;
                rd_valid_reg    <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (!scan_issued_reg)
                begin
                    rd_valid_reg <= 1'b1;
                    rd_addr_reg  <= scan_addr_reg;
                    if (scan_addr_reg == ptr_idx)
                    begin
                        scan_issued_reg <= 1'b1;
                    end
                    else
                    begin
                        scan_addr_reg <= wrap_inc(scan_addr_reg, lim);
                    end
                end
                else
                begin
                    rd_valid_reg <= 1'b0;
                end
                if (scan_hit)
                begin
                    ptr_reg <= (rdata_reg == '0) ? fcta_pkg::val_t'(rd_addr_reg) : '0;
                end
            end
        end
    end

`ifndef SYNTH
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && sts.scan_done) |=> (ptr_reg < $past(lim)))
        else $error("pointer left outside the table after a scan");
    a_free_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.do_load |=> (free_reg <= $past(free_reg)))
        else $error("free count rose without a load");
    a_scan_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_start |=> !sts.scan_done)
        else $error("stale read data ended a new scan");
`endif

endmodule

`default_nettype wire

@@ design/fcta_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcta_ctrl
// Sequencer for clearing, table access, allocation scan and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module fcta_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output fcta_pkg::fcta_cmd_t      cmd,
    input  wire fcta_pkg::fcta_sts_t sts
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDDATA = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.op)
                    fcta_pkg::OP_READ, fcta_pkg::OP_WRITE:
                    begin
                        if (sts.idx_bad)
                        begin
                            cmd.set_invalid = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_RDDATA;
                        end
                    end
                    fcta_pkg::OP_ALLOC:
                    begin
                        priority if (sts.ptr_zero)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_DONE;
                        end
                        else if (sts.ptr_bad)
                        begin
                            cmd.set_invalid = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.alloc_start = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                    fcta_pkg::OP_LOAD:
                    begin
                        cmd.do_load = 1'b1;
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDDATA:
            begin
                cmd.rd_finish = 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");
    a_clear_only_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("table clear restarted outside reset");
`endif

endmodule

`default_nettype wire

@@ design/fat_cluster_table_allocator.sv @@
// ----------------------------------------------------------------------------
// fat_cluster_table_allocator
// Cluster allocation table with next-fit allocator and APB limit register.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        operation, cluster_index, new_value
//  out_ch    out  valid/ready        status, entry_value, end_of_chain, free_count
//  apb       in   psel/penable       entries_in_use at byte address 0
//
//  After reset the table is cleared, one entry per cycle, with in_ch.ready
//  low. One item at a time, single read port on the table.
//  Read, write: accept, execute, read data, result; load and rejected items
//  skip the read. Allocate: execute, then scan from pointer+1, one entry per cycle.
//  A stalled result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_cluster_table_allocator #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fcta_in_if.sink          in_ch,
    fcta_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    fcta_pkg::cfg_t      entries_in_use_reg;
    fcta_pkg::fcta_cmd_t cmd;
    fcta_pkg::fcta_sts_t sts;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - fcta_pkg::CFG_W){1'b0}}, entries_in_use_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= fcta_pkg::ENTRIES_RESET;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            entries_in_use_reg <= pwdata[fcta_pkg::CFG_W-1:0];
        end
    end

    fcta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    fcta_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .entries_in_use (entries_in_use_reg),
        .operation      (in_ch.operation),
        .cluster_index  (in_ch.cluster_index),
        .new_value      (in_ch.new_value),
        .status         (out_ch.status),
        .entry_value    (out_ch.entry_value),
        .end_of_chain   (out_ch.end_of_chain),
        .free_count     (out_ch.free_count)
    );

endmodule

`default_nettype wire
